### sv/dgr_pkg.sv
// Shared constants, command codes and control types of the graph reachability core.
`timescale 1ns / 1ps

package dgr_pkg;

    localparam int MAX_NODES = 64;                      // node capacity
    localparam int NODE_W    = 6;                       // node index width
    localparam int ROW_DEPTH = 2 ** NODE_W;             // adjacency rows with storage
    localparam int ROW_W     = 2 ** NODE_W;             // one bit per destination
    localparam int CNT_W     = $clog2(MAX_NODES + 1);   // node count width
    localparam int ADD_W     = 7;                       // append count field width
    localparam int SUM_W     = ((CNT_W > ADD_W) ? CNT_W : ADD_W) + 1;
    localparam int IN_W      = 24;                      // packed input tdata
    localparam int OUT_W     = 8;                       // packed output tdata

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_DEL    = 3'd2,
        CMD_HAS    = 3'd3,
        CMD_PATH   = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    // Control from the sequencer to the search frontier.
    typedef struct packed {
        logic              start;    // load source as the only pending node
        logic [NODE_W-1:0] src;
        logic              issue;    // picked node was sent to the row memory
        logic              row_vld;  // row data of the last issued node present
    } t_front_ctl;

    // Status from the search frontier.
    typedef struct packed {
        logic              pick_vld; // a pending node is waiting for expansion
        logic [NODE_W-1:0] pick_idx; // lowest pending node
    } t_front_stat;

endpackage

### sv/dgr_frontier.sv
// Search frontier: visited and pending node sets, lowest pending node pick.
`timescale 1ns / 1ps

module dgr_frontier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dgr_pkg::t_front_ctl        i_ctl,
    input  logic [dgr_pkg::ROW_W-1:0]  i_row,
    output dgr_pkg::t_front_stat       o_stat
);
    import dgr_pkg::*;

    logic [ROW_W-1:0]  r_visited;
    logic [ROW_W-1:0]  r_pending;
    logic [ROW_W-1:0]  n_visited;
    logic [ROW_W-1:0]  n_pending;
    logic [ROW_W-1:0]  pick_hot;
    logic [ROW_W-1:0]  fresh;
    logic [ROW_W-1:0]  src_hot;
    logic [NODE_W-1:0] pick_idx;

    // Isolate the lowest pending bit.
    assign pick_hot = r_pending & (~r_pending + ROW_W'(1));
    assign fresh    = i_ctl.row_vld ? (i_row & ~r_visited) : '0;
    assign src_hot  = ROW_W'(1) << i_ctl.src;

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (pick_hot[i]) begin
                pick_idx = pick_idx | NODE_W'(i);
            end
        end
    end

    always_comb begin
        if (i_ctl.start) begin
            n_visited = src_hot;
            n_pending = src_hot;
        end else begin
            n_visited = r_visited | fresh;
            n_pending = (r_pending & ~(i_ctl.issue ? pick_hot : '0)) | fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_pending <= '0;
        end else begin
            r_visited <= n_visited;
            r_pending <= n_pending;
        end
    end

    assign o_stat.pick_vld = |r_pending;
    assign o_stat.pick_idx = pick_idx;

`ifndef SYNTH
    a_pending_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~r_visited) == '0)
        else $error("pending node not marked visited");

    a_issue_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.issue |-> (r_pending != '0))
        else $error("node issued with empty frontier");

    a_start_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> ($onehot(r_visited) && r_pending == r_visited))
        else $error("search start did not seed one node");
`endif

endmodule

### sv/directed_graph_reachability_core.sv
// Top level: directed graph store with edge commands and reachability search.
//
//  channel  | direction | handshake              | tdata fields, low bit first
//  ---------+-----------+------------------------+----------------------------------------
//  s        | in        | i_s_tvalid/o_s_tready  | cmd, src_node, dst_node, add_count
//  m        | out       | o_m_tvalid/i_m_tready  | answer, first_new_node, full_res
//
// One command is worked at a time; every command gives one result transaction.
// Edge commands read the row, check it and write it back, then give the result; append
// zeroes one new row per cycle; clear and immediate answers go straight to the result.
// A path search ends early on a hit; a new row read issues while the last row is in flight
// whenever another node is pending. Reset clears control.
// A held result stalls the core only when the next result is ready to load.
`timescale 1ns / 1ps

module directed_graph_reachability_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // cmd[2:0], src_node[8:3], dst_node[14:9], add_count[21:15], zero pad
    input  logic [dgr_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // answer[0], first_new_node[6:1], full_res[7]
    output logic [dgr_pkg::OUT_W-1:0] o_m_tdata
);
    import dgr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_SEARCH,
        ST_RESP
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [NODE_W-1:0]  r_src;
    logic [NODE_W-1:0]  r_dst;
    logic [CNT_W-1:0]   r_node_total;
    logic [CNT_W-1:0]   r_fill_addr;
    logic [ADD_W-1:0]   r_fill_left;
    logic               r_ans;
    logic [NODE_W-1:0]  r_first;
    logic               r_full;
    logic               r_out_vld;
    logic [OUT_W-1:0]   r_out_data;

    logic [ROW_W-1:0]   r_mem [ROW_DEPTH];
    logic [ROW_W-1:0]   r_rd_data;
    logic               r_rd_vld;

    logic               acc_in;
    t_cmd               in_cmd;
    logic [NODE_W-1:0]  in_src;
    logic [NODE_W-1:0]  in_dst;
    logic [ADD_W-1:0]   in_cnt;
    logic               in_range;
    logic [SUM_W-1:0]   app_sum;
    logic               present;
    logic [ROW_W-1:0]   bit_mask;
    logic               hit;
    logic               mem_re;
    logic [NODE_W-1:0]  mem_ra;
    logic               mem_we;
    logic [NODE_W-1:0]  mem_wa;
    logic [ROW_W-1:0]   mem_wd;
    t_front_ctl         front_ctl;
    t_front_stat        front_stat;

    assign o_s_tready = (r_state == ST_IDLE);
    assign acc_in     = i_s_tvalid && o_s_tready;
    assign in_cmd     = t_cmd'(i_s_tdata[2:0]);
    assign in_src     = i_s_tdata[8:3];
    assign in_dst     = i_s_tdata[14:9];
    assign in_cnt     = i_s_tdata[21:15];
    assign in_range   = (SUM_W'(in_src) < SUM_W'(r_node_total)) &&
                        (SUM_W'(in_dst) < SUM_W'(r_node_total));
    assign app_sum    = SUM_W'(r_node_total) + SUM_W'(in_cnt);

    assign bit_mask   = ROW_W'(1) << r_dst;
    assign present    = r_rd_data[r_dst];
    assign hit        = (r_state == ST_SEARCH) && r_rd_vld && present;

    always_comb begin
        front_ctl.start   = acc_in && (in_cmd == CMD_PATH) && (in_src != in_dst) && in_range;
        front_ctl.src     = in_src;
        front_ctl.issue   = (r_state == ST_SEARCH) && front_stat.pick_vld && !hit;
        front_ctl.row_vld = (r_state == ST_SEARCH) && r_rd_vld;
    end

    dgr_frontier u_frontier (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (front_ctl),
        .i_row   (r_rd_data),
        .o_stat  (front_stat)
    );

    // Row memory port control.
    always_comb begin
        mem_re = (r_state == ST_EDGE_RD) || front_ctl.issue;
        mem_ra = (r_state == ST_SEARCH) ? front_stat.pick_idx : r_src;
        mem_we = 1'b0;
        mem_wa = r_src;
        mem_wd = r_rd_data;
        unique case (r_state)
            ST_APPEND: begin
                mem_we = (r_fill_left != '0) && (SUM_W'(r_fill_addr) < SUM_W'(ROW_DEPTH));
                mem_wa = NODE_W'(r_fill_addr);
                mem_wd = '0;
            end
            ST_EDGE_CHK: begin
                if (r_cmd == CMD_ADD && !present) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd_data | bit_mask;
                end else if (r_cmd == CMD_DEL && present) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd_data & ~bit_mask;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= mem_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_total <= '0;
            r_fill_left  <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (r_out_vld && i_m_tready && (r_state != ST_RESP)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        r_cmd   <= in_cmd;
                        r_src   <= in_src;
                        r_dst   <= in_dst;
                        r_ans   <= 1'b0;
                        r_first <= '0;
                        r_full  <= 1'b0;
                        r_state <= ST_RESP;
                        case (in_cmd)
                            CMD_APPEND: begin
                                r_first <= NODE_W'(r_node_total);
                                if (app_sum > SUM_W'(MAX_NODES)) begin
                                    r_full <= 1'b1;
                                end else begin
                                    r_node_total <= app_sum[CNT_W-1:0];
                                    r_fill_addr  <= r_node_total;
                                    r_fill_left  <= in_cnt;
                                    r_state      <= ST_APPEND;
                                end
                            end
                            CMD_ADD, CMD_DEL, CMD_HAS: begin
                                if (in_range) begin
                                    r_state <= ST_EDGE_RD;
                                end
                            end
                            CMD_PATH: begin
                                if (in_src == in_dst) begin
                                    r_ans <= 1'b1;
                                end else if (in_range) begin
                                    r_state <= ST_SEARCH;
                                end
                            end
                            CMD_CLEAR: begin
                                r_node_total <= '0;
                            end
                            default: begin
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_APPEND: begin
                    // Zero one new row per cycle.
                    if (r_fill_left == '0) begin
                        r_state <= ST_RESP;
                    end else begin
                        r_fill_addr <= r_fill_addr + CNT_W'(1);
                        r_fill_left <= r_fill_left - ADD_W'(1);
                    end
                end
                ST_EDGE_RD: begin
                    r_state <= ST_EDGE_CHK;
                end
                ST_EDGE_CHK: begin
                    r_ans   <= (r_cmd == CMD_ADD) ? !present : present;
                    r_state <= ST_RESP;
                end
                ST_SEARCH: begin
                    if (hit) begin
                        r_ans   <= 1'b1;
                        r_state <= ST_RESP;
                    end else if (!front_stat.pick_vld && !r_rd_vld) begin
                        r_state <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (!r_out_vld || i_m_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= {r_full, r_first, r_ans};
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTH
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_total <= CNT_W'(MAX_NODES))
        else $error("node count above capacity");

    a_row_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> r_rd_vld)
        else $error("row read lost its valid flag");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_APPEND || r_state == ST_EDGE_CHK))
        else $error("row write outside append or edge update");

    a_no_read_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("row read and write in the same cycle");
`endif

endmodule

### tb/directed_graph_reachability_core_tb.sv
// Testbench for the graph reachability core: stream stimulus and a scoreboard with a graph model.
`timescale 1ns / 1ps

// Result fields in tdata order, answer in bit 0.
typedef struct packed {
    logic       full;
    logic [5:0] first_node;
    logic       answer;
} t_graph_result;

class t_graph_scoreboard;
    int unsigned   errors;
    int unsigned   node_cnt;
    logic [63:0]   rows [64];
    t_graph_result pending_answers[$];

    function new();
        errors   = 0;
        node_cnt = 0;
        foreach (rows[i]) rows[i] = '0;
    endfunction

    // Breadth-first closure: true when dst sits in the row of any node reachable from src.
    function bit reaches(logic [5:0] src, logic [5:0] dst);
        logic [63:0] seen;
        logic [63:0] frontier;
        logic [63:0] nxt;
        seen     = 64'd1 << src;
        frontier = seen;
        while (frontier != '0) begin
            nxt = '0;
            for (int n = 0; n < 64; n++)
                if (frontier[n]) nxt |= rows[n];
            if (nxt[dst]) return 1'b1;
            frontier = nxt & ~seen;
            seen    |= nxt;
        end
        return 1'b0;
    endfunction

    function void note_command(logic [2:0] op, logic [5:0] src, logic [5:0] dst,
                               logic [6:0] cnt);
        t_graph_result r;
        bit            ok;
        r  = '0;
        ok = (src < node_cnt) && (dst < node_cnt);
        case (op)
            dgr_pkg::CMD_APPEND: begin
                r.first_node = 6'(node_cnt);
                if (node_cnt + cnt > dgr_pkg::MAX_NODES) begin
                    r.full = 1'b1;
                end else begin
                    for (int i = 0; i < cnt; i++) rows[node_cnt + i] = '0;
                    node_cnt += cnt;
                end
            end
            dgr_pkg::CMD_ADD: begin
                if (ok && !rows[src][dst]) begin
                    rows[src][dst] = 1'b1;
                    r.answer       = 1'b1;
                end
            end
            dgr_pkg::CMD_DEL: begin
                if (ok && rows[src][dst]) begin
                    rows[src][dst] = 1'b0;
                    r.answer       = 1'b1;
                end
            end
            dgr_pkg::CMD_HAS:   r.answer = ok && rows[src][dst];
            dgr_pkg::CMD_PATH:  r.answer = (src == dst) || (ok && reaches(src, dst));
            dgr_pkg::CMD_CLEAR: node_cnt = 0;
            default: ;
        endcase
        pending_answers.insert(pending_answers.size(), r);
    endfunction

    function void cmp_field(string name, logic [5:0] want, logic [5:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_answer(logic [7:0] data);
        t_graph_result got;
        t_graph_result want;
        got = data;
        if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %h", $time, data);
            return;
        end
        want = pending_answers.pop_front();
        cmp_field("answer", 6'(want.answer), 6'(got.answer));
        cmp_field("first_new_node", want.first_node, got.first_node);
        cmp_field("full_res", 6'(want.full), 6'(got.full));
    endfunction

    function int unsigned pending();
        return pending_answers.size();
    endfunction
endclass

module directed_graph_reachability_core_tb;
    import dgr_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam int RANDOM_ITEMS    = 1275;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 120;
    localparam int WATCHDOG_CYCLES = 5000;

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             o_m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    int                src_idle_pct = 0;
    int                dst_idle_pct = 0;
    logic              hold_req = 1'b0;
    int                hold_cnt = 0;
    int                quiet_cycles = 0;
    t_graph_scoreboard sb;

    directed_graph_reachability_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Offer one command, hold it until the core takes it, then log it with the scoreboard.
    task automatic issue_command(logic [2:0] op, logic [5:0] src, logic [5:0] dst,
                                 logic [6:0] cnt);
        while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, cnt, dst, src, op};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(op, src, dst, cnt);
    endtask

    function automatic logic [5:0] pick_node(int unsigned n);
        if (n > 0 && $urandom_range(0, 9) != 0) return 6'($urandom_range(0, n - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [6:0] append_count(int unsigned n);
        int unsigned room;
        int unsigned p;
        room = MAX_NODES - n;
        p    = $urandom_range(0, 99);
        if (p < 15) return 7'($urandom_range(0, 127));  // often overflows capacity
        if (p < 25 || room == 0) return 7'(room);
        return 7'($urandom_range(1, (room < 10) ? room : 10));
    endfunction

    task automatic random_command();
        int unsigned n;
        int unsigned pick;
        logic [2:0]  op;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [6:0]  cnt;
        n    = sb.node_cnt;
        pick = $urandom_range(0, 99);
        src  = pick_node(n);
        dst  = pick_node(n);
        cnt  = 7'($urandom_range(0, 127));
        if (pick < 12) begin
            op  = CMD_APPEND;
            cnt = append_count(n);
        end else if (pick < 42) begin
            op = CMD_ADD;
            // grow chains now and then so searches run deep
            if (n > 1 && $urandom_range(0, 2) == 0) dst = 6'((src + 1) % n);
        end else if (pick < 62) begin
            op = (pick < 52) ? CMD_DEL : CMD_HAS;
            // steer toward existing edges
            if (n > 0 && src < n && $urandom_range(0, 1) == 1)
                for (int k = 0; k < 12 && !sb.rows[src][dst]; k++)
                    dst = 6'($urandom_range(0, n - 1));
        end else if (pick < 94) begin
            op = CMD_PATH;
        end else if (pick < 97) begin
            op = CMD_CLEAR;
        end else begin
            op = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
        end
        issue_command(op, src, dst, cnt);
    endtask

    // Result side: check each transaction, then pick tready for the next cycle.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) sb.check_answer(o_m_tdata);
            if (hold_req && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(1, 100) > dst_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("[directed_graph_reachability_core] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        sb = new();
        src_idle_pct = 17;
        dst_idle_pct = 69;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every row first so no later command touches an unwritten row.
        issue_command(CMD_APPEND, 6'd0, 6'd0, 7'd64);
        issue_command(CMD_APPEND, 6'd0, 6'd0, 7'd1);    // over capacity
        issue_command(CMD_APPEND, 6'd0, 6'd0, 7'd0);    // first index wraps to zero
        issue_command(CMD_ADD, 6'd63, 6'd0, 7'd0);
        issue_command(CMD_ADD, 6'd63, 6'd0, 7'd0);      // already present
        issue_command(CMD_ADD, 6'd0, 6'd63, 7'd0);
        issue_command(CMD_ADD, 6'd0, 6'd21, 7'd0);
        issue_command(CMD_HAS, 6'd63, 6'd0, 7'd0);
        issue_command(CMD_HAS, 6'd0, 6'd62, 7'd0);
        issue_command(CMD_PATH, 6'd63, 6'd21, 7'd0);    // two hops
        issue_command(CMD_PATH, 6'd63, 6'd63, 7'd0);
        issue_command(CMD_PATH, 6'd21, 6'd0, 7'd0);
        issue_command(CMD_DEL, 6'd63, 6'd0, 7'd0);
        issue_command(CMD_DEL, 6'd63, 6'd0, 7'd0);      // already gone
        issue_command(CMD_CLEAR, 6'd0, 6'd0, 7'd0);
        issue_command(CMD_HAS, 6'd63, 6'd0, 7'd0);      // out of range
        issue_command(CMD_PATH, 6'd42, 6'd42, 7'd0);    // self path out of range
        issue_command(CMD_PATH, 6'd1, 6'd2, 7'd0);
        issue_command(CMD_ADD, 6'd3, 6'd4, 7'd0);
        issue_command(CMD_APPEND, 6'd0, 6'd0, 7'd127);
        issue_command(CMD_APPEND, 6'd0, 6'd0, 7'd65);
        issue_command(CMD_APPEND, 6'd0, 6'd0, 7'd64);
        issue_command(CMD_CLEAR, 6'd0, 6'd0, 7'd0);
        issue_command(CMD_RSVD6, 6'd63, 6'd63, 7'd127);
        issue_command(CMD_RSVD7, 6'd63, 6'd63, 7'd127);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                src_idle_pct = 69;
                dst_idle_pct = 17;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
                hold_req    <= 1'b1;  // long receiver stall, sender keeps pushing
            end
            random_command();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[directed_graph_reachability_core] OK");
        end else begin
            $display("[directed_graph_reachability_core] ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
sv/dgr_pkg.sv
sv/dgr_frontier.sv
sv/directed_graph_reachability_core.sv
tb/directed_graph_reachability_core_tb.sv
